// ----- src/dttm_pkg.sv -----
// Shared types and constants for the timestamp-to-minutes converter.
// No dependencies; used by every module of the block.
package dttm_pkg;

  typedef enum logic [2:0] {
    KIND_DATE       = 3'd0,
    KIND_STRICT_DAY = 3'd1,
    KIND_STRICT_MIN = 3'd2,
    KIND_FAST_DAY   = 3'd3,
    KIND_FAST_MIN   = 3'd4
  } dttm_kind_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;

  localparam int YearW = 18;
  localparam int MonW  = 7;
  localparam int HmW   = 13;
  localparam int DayW  = 28;
  localparam int MinW  = 37;

  // (153*mm+2)/5 as one multiply: (mm*153*52429 + 2*52429) >> 18
  localparam logic [29:0] DOY_MUL   = 30'd8021637;
  localparam logic [29:0] DOY_ADD   = 30'd104858;
  // y/400 = ((y >> 4) * 20972) >> 19
  localparam logic [14:0] ERA_RECIP = 15'd20972;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  // civil offset plus one era (the year is biased by 400)
  localparam logic [19:0] CIVIL_BIAS = 20'd865565;
  localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;

  typedef struct packed {
    logic             pre_ok;
    logic             want_min;
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [MonW-1:0]  mday;
    logic [HmW-1:0]   hm;
  } dttm_item_t;

endpackage

// ----- src/dttm_front.sv -----
// Front end: accepts text words, checks format per kind and extracts fields.
// Depends on dttm_pkg.
module dttm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [135:0]        in_tdata,
  input  logic [2:0]          in_tuser,
  output logic                q_valid,
  input  logic                q_ready,
  output dttm_pkg::dttm_item_t q_item
);
  import dttm_pkg::*;

  logic [7:0]        ch [16];
  logic signed [8:0] dv [16];
  logic [15:0]       dig;
  logic [4:0]        len;
  logic signed [18:0] yr;
  logic signed [12:0] mon, mdy, hr, mn;
  logic        sd_ok, st_ok, fd_ok, fm_ok, len10, len16;
  logic        ok;
  logic        take;
  dttm_item_t  item;
  logic        fr_valid_r, fr_valid_nxt;
  dttm_item_t  fr_item_r, fr_item_nxt;

  function automatic logic signed [12:0] num2(logic signed [8:0] a, logic signed [8:0] b);
    return 13'(a) * 13'sd10 + 13'(b);
  endfunction

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ch[i]  = in_tdata[8*i +: 8];
      dv[i]  = $signed({1'b0, ch[i]}) - 9'sd48;
      dig[i] = (ch[i] >= CH_ZERO) && (ch[i] <= CH_NINE);
    end
  end

  assign len = in_tdata[132:128];
  assign len10 = len >= 5'd10;
  assign len16 = len >= 5'd16;

  assign yr  = 19'(dv[0]) * 19'sd1000 + 19'(dv[1]) * 19'sd100 + 19'(dv[2]) * 19'sd10
             + 19'(dv[3]);
  assign mon = num2(dv[5], dv[6]);
  assign mdy = num2(dv[8], dv[9]);
  assign hr  = num2(dv[11], dv[12]);
  assign mn  = num2(dv[14], dv[15]);

  assign sd_ok = (ch[4] == CH_DASH) && (ch[7] == CH_DASH) && (&dig[3:0]) && (&dig[6:5])
               && (&dig[9:8]);
  assign st_ok = (ch[10] == CH_SPACE) && (ch[13] == CH_COLON) && (&dig[12:11])
               && (&dig[15:14]);
  assign fd_ok = (ch[0] != CH_UPPER_N) && (ch[4] == CH_DASH) && (ch[7] == CH_DASH)
               && (ch[10] == CH_SPACE) && !yr[18]
               && (mon > 13'sd0) && (mon <= 13'sd12) && (mdy > 13'sd0) && (mdy <= 13'sd31);
  assign fm_ok = (ch[13] == CH_COLON) && (hr >= 13'sd0) && (hr <= 13'sd23)
               && (mn >= 13'sd0) && (mn <= 13'sd59);

  always_comb begin
    unique case (dttm_kind_t'(in_tuser))
      KIND_DATE:       ok = len10 && sd_ok;
      KIND_STRICT_DAY: ok = len16 && sd_ok;
      KIND_STRICT_MIN: ok = len16 && sd_ok && st_ok;
      KIND_FAST_DAY:   ok = fd_ok;
      KIND_FAST_MIN:   ok = fd_ok && fm_ok;
      default:         ok = 1'b0;
    endcase
  end

  always_comb begin
    item.pre_ok   = ok;
    item.want_min = (in_tuser == KIND_STRICT_MIN) || (in_tuser == KIND_FAST_MIN);
    item.year     = yr[YearW-1:0];
    item.month    = mon[MonW-1:0];
    item.mday     = mdy[MonW-1:0];
    item.hm       = HmW'(hr * 13'sd60 + mn);
  end

  assign in_tready = !fr_valid_r || q_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (take) begin
      fr_valid_nxt = 1'b1;
      fr_item_nxt  = item;
    end else if (q_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

  assign q_valid = fr_valid_r;
  assign q_item  = fr_item_r;

endmodule

// ----- src/dttm_fifo.sv -----
// Short queue of parsed words between the front end and the calendar pipeline.
// Depends on dttm_pkg for the word type.
module dttm_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  dttm_pkg::dttm_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output dttm_pkg::dttm_item_t pop_item
);
  import dttm_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  dttm_item_t       slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != CntW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/dttm_back.sv -----
// Calendar pipeline: six stages from parsed fields to day and minute counts.
// Depends on dttm_pkg; the last stage is the output register.
module dttm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dttm_pkg::dttm_item_t in_item,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_ok,
  output logic [27:0]         out_day,
  output logic [36:0]         out_minutes
);
  import dttm_pkg::*;

  logic        en;
  logic [5:0]  vld_r, vld_nxt;

  logic             le2;
  logic [MonW-1:0]  mm;

  logic             s1_ok_r, s1_min_r;
  logic [YearW-1:0] s1_yp_r, s1_yp_nxt;
  logic [29:0]      s1_dprod_r, s1_dprod_nxt;
  logic [MonW-1:0]  s1_mday_r;
  logic [HmW-1:0]   s1_hm_r;

  logic             s2_ok_r, s2_min_r;
  logic [YearW-1:0] s2_yp_r;
  logic [28:0]      s2_qprod_r, s2_qprod_nxt;
  logic signed [12:0] s2_doy_r, s2_doy_nxt;
  logic [HmW-1:0]   s2_hm_r;

  logic             s3_ok_r, s3_min_r;
  logic [9:0]       s3_q_r, s3_q_nxt;
  logic [8:0]       s3_yoe_r, s3_yoe_nxt;
  logic signed [12:0] s3_doy_r;
  logic [HmW-1:0]   s3_hm_r;

  logic [1:0]       cent;
  logic             s4_ok_r, s4_min_r;
  logic [26:0]      s4_eprod_r, s4_eprod_nxt;
  logic signed [18:0] s4_doe_r, s4_doe_nxt;
  logic [HmW-1:0]   s4_hm_r;

  logic             s5_ok_r, s5_ok_nxt, s5_min_r;
  logic signed [DayW-1:0] s5_day_r, s5_day_nxt;
  logic [HmW-1:0]   s5_hm_r;

  logic             out_ok_r, out_ok_nxt;
  logic [DayW-1:0]  out_day_r, out_day_nxt;
  logic [MinW-1:0]  out_min_r, out_min_nxt;

  assign en       = !vld_r[5] || out_tready;
  assign in_ready = en;
  assign vld_nxt  = en ? {vld_r[4:0], in_valid} : vld_r;

  // stage 1: March-based year and month, month-day product
  always_comb begin
    le2          = in_item.month <= 7'd2;
    s1_yp_nxt    = in_item.year + (le2 ? 18'd399 : 18'd400);
    mm           = le2 ? in_item.month + 7'd9 : in_item.month - 7'd3;
    s1_dprod_nxt = 30'(mm) * DOY_MUL + DOY_ADD;
  end

  // stage 2: era quotient product, day of year
  always_comb begin
    s2_qprod_nxt = 29'(s1_yp_r[YearW-1:4]) * 29'(ERA_RECIP);
    s2_doy_nxt   = $signed({1'b0, s1_dprod_r[29:18]}) + $signed(13'(s1_mday_r)) - 13'sd1;
  end

  // stage 3: era and year of era
  always_comb begin
    s3_q_nxt   = s2_qprod_r[28:19];
    s3_yoe_nxt = 9'(s2_yp_r - 18'(s3_q_nxt) * 18'd400);
  end

  // stage 4: day of era, era base
  always_comb begin
    if (s3_yoe_r >= 9'd300) begin
      cent = 2'd3;
    end else if (s3_yoe_r >= 9'd200) begin
      cent = 2'd2;
    end else if (s3_yoe_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    s4_doe_nxt = $signed(19'(s3_yoe_r)) * 19'sd365 + $signed(19'(s3_yoe_r[8:2]))
               - $signed(19'(cent)) + 19'(s3_doy_r);
    s4_eprod_nxt = 27'(s3_q_r) * 27'(DAYS_PER_ERA);
  end

  // stage 5: day count, drop negative days in minute kinds
  always_comb begin
    s5_day_nxt = $signed({1'b0, s4_eprod_r}) + DayW'(s4_doe_r) - $signed(DayW'(CIVIL_BIAS));
    s5_ok_nxt  = s4_ok_r && !(s4_min_r && s5_day_nxt[DayW-1]);
  end

  // stage 6: minute count and output zeroing
  always_comb begin
    out_ok_nxt  = s5_ok_r;
    out_day_nxt = s5_ok_r ? s5_day_r : '0;
    out_min_nxt = (s5_ok_r && s5_min_r)
                ? MinW'(s5_day_r[26:0]) * MinW'(MINUTES_PER_DAY) + MinW'(s5_hm_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok_r    <= in_item.pre_ok;
      s1_min_r   <= in_item.want_min;
      s1_yp_r    <= s1_yp_nxt;
      s1_dprod_r <= s1_dprod_nxt;
      s1_mday_r  <= in_item.mday;
      s1_hm_r    <= in_item.hm;

      s2_ok_r    <= s1_ok_r;
      s2_min_r   <= s1_min_r;
      s2_yp_r    <= s1_yp_r;
      s2_qprod_r <= s2_qprod_nxt;
      s2_doy_r   <= s2_doy_nxt;
      s2_hm_r    <= s1_hm_r;

      s3_ok_r    <= s2_ok_r;
      s3_min_r   <= s2_min_r;
      s3_q_r     <= s3_q_nxt;
      s3_yoe_r   <= s3_yoe_nxt;
      s3_doy_r   <= s2_doy_r;
      s3_hm_r    <= s2_hm_r;

      s4_ok_r    <= s3_ok_r;
      s4_min_r   <= s3_min_r;
      s4_eprod_r <= s4_eprod_nxt;
      s4_doe_r   <= s4_doe_nxt;
      s4_hm_r    <= s3_hm_r;

      s5_ok_r    <= s5_ok_nxt;
      s5_min_r   <= s4_min_r;
      s5_day_r   <= s5_day_nxt;
      s5_hm_r    <= s4_hm_r;

      out_ok_r   <= out_ok_nxt;
      out_day_r  <= out_day_nxt;
      out_min_r  <= out_min_nxt;
    end
  end

  assign out_tvalid  = vld_r[5];
  assign out_ok      = out_ok_r;
  assign out_day     = out_day_r;
  assign out_minutes = out_min_r;

endmodule

// ----- src/datetime_text_to_minutes.sv -----
// From the accepting edge to out_tvalid: the front register is loaded at that edge,
// then 1 queue slot and 6 calendar stages follow; the last is the output register.
// Throughput: one word per cycle while out_tready is high (single-issue calendar pipeline).
// Front and pipeline stall independently through a QUEUE_DEPTH-entry queue.
// Reset (rst_n low, synchronous) empties front register, queue and pipeline.
module datetime_text_to_minutes #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // text_low_chars, text_high_chars, text_length, pad
  input  logic [2:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // day_number, minute_count, pad
  output logic [0:0]   out_tuser   // valid_res
);
  import dttm_pkg::*;

  logic        fq_valid, fq_ready;
  dttm_item_t  fq_item;
  logic        qb_valid, qb_ready;
  dttm_item_t  qb_item;
  logic        res_ok;
  logic [27:0] res_day;
  logic [36:0] res_min;

  dttm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  dttm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  dttm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (qb_valid),
    .in_ready    (qb_ready),
    .in_item     (qb_item),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_ok      (res_ok),
    .out_day     (res_day),
    .out_minutes (res_min)
  );

  assign out_tdata = {7'b0, res_min, res_day};
  assign out_tuser = res_ok;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 72'd0)
    else $error("invalid result carries nonzero counts");

  a_minutes_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[64:28] != 37'd0) |-> out_tuser[0] && !out_tdata[27])
    else $error("minute count with invalid or negative day");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
